// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; take this file in with an include of its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define AEPS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed: same-cycle implication");

// Next-cycle implication, switched off while reset is held.
`define AEPS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed: next-cycle implication");

`endif

// ===== src/aeps_pkg.sv =====
// Shared types and constants of the active/expired priority scheduler.
// No dependencies; used by every module of the block.
`default_nettype none

package aeps_pkg;

  // Default sizing.
  localparam int LEVELS_DEF     = 4;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF    = 8;

  // Fixed field widths of the ports.
  localparam int TASK_ID_W = 8;
  localparam int STATIC_W  = 3;
  localparam int CURRENT_W = 2;
  localparam int DYN_W     = 2;

  // Operation codes.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath and output register.
  typedef struct packed {
    logic capture;   // latch the input beat
    logic execute;   // update queues and access the task store
    logic finish;    // load the result register
  } ctrl_cmd_t;

  // One result beat.
  typedef struct packed {
    logic                 found;
    logic [TASK_ID_W-1:0] task_id;
    logic [STATIC_W-1:0]  static_level;
    logic [DYN_W-1:0]     dynamic_level;
    logic                 went_expired;
    logic                 overflow;
  } result_t;

endpackage

`default_nettype wire

// ===== src/active_expired_priority_scheduler_unit.sv =====
// Top level of the active/expired priority scheduler: controller, datapath
// and the output result register. Depends on aeps_pkg, aeps_ctrl, aeps_datapath.
`default_nettype none

// Each accepted beat passes through the controller's execute and load states:
// the first updates the level queue's pointers and count and accesses the task
// store, the second loads the registered store read into the result register.
// The next beat is accepted in the cycle its predecessor's result is loaded,
// while the result side keeps up; no beat is taken while one is in its execute
// state, as the single-port task store is accessed once per beat. A result
// waiting in the output register holds the block in its load step and stalls
// the input until that result is taken. The task store is not cleared after
// reset; only slots that were written ever reach the result. Enqueue returns
// found = 1 when the task was queued, or overflow = 1 when its level queue was
// full; a dequeue with both banks empty returns an all-zero beat.
module active_expired_priority_scheduler_unit #(
  parameter int LEVELS     = aeps_pkg::LEVELS_DEF,
  parameter int FIFO_DEPTH = aeps_pkg::FIFO_DEPTH_DEF,
  parameter int ID_BITS    = aeps_pkg::ID_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_operation,
  input  wire logic [aeps_pkg::TASK_ID_W-1:0]     in_task_id,
  input  wire logic [aeps_pkg::STATIC_W-1:0]      in_static_level,
  input  wire logic [aeps_pkg::CURRENT_W-1:0]     in_current_level,
  input  wire logic                               in_demote,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_found,
  output logic [aeps_pkg::TASK_ID_W-1:0]          out_task_id,
  output logic [aeps_pkg::STATIC_W-1:0]           out_static_level,
  output logic [aeps_pkg::DYN_W-1:0]              out_dynamic_level,
  output logic                                    out_went_expired,
  output logic                                    out_overflow
);

  aeps_pkg::ctrl_cmd_t cmd;
  aeps_pkg::result_t   result;
  aeps_pkg::result_t   out_res_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_busy;

  assign out_busy = out_valid_r && out_stall;

  aeps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  aeps_datapath #(
    .LEVELS     (LEVELS),
    .FIFO_DEPTH (FIFO_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_task_id       (in_task_id),
    .in_static_level  (in_static_level),
    .in_current_level (in_current_level),
    .in_demote        (in_demote),
    .result           (result)
  );

  // Output beat valid: set on load, cleared when taken.
  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_res_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_res_r.found;
  assign out_task_id       = out_res_r.task_id;
  assign out_static_level  = out_res_r.static_level;
  assign out_dynamic_level = out_res_r.dynamic_level;
  assign out_went_expired  = out_res_r.went_expired;
  assign out_overflow      = out_res_r.overflow;

endmodule

`default_nettype wire

// ===== src/aeps_ctrl.sv =====
// Controller state machine of the scheduler: sequences capture, execute and
// result load. Depends on aeps_pkg.
`default_nettype none

module aeps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_busy,
  output logic                   in_stall,
  output aeps_pkg::ctrl_cmd_t    cmd
);

  aeps_pkg::state_t state_r;
  aeps_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aeps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a new beat may enter in the cycle its predecessor's result is loaded.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aeps_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = aeps_pkg::ST_EXEC;
      end
      aeps_pkg::ST_EXEC: begin
        state_nxt = aeps_pkg::ST_DONE;
      end
      aeps_pkg::ST_DONE: begin
        if (!out_busy) state_nxt = in_valid ? aeps_pkg::ST_EXEC : aeps_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = aeps_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall    = 1'b1;
    cmd.execute = 1'b0;
    cmd.finish  = 1'b0;
    case (state_r)
      aeps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      aeps_pkg::ST_EXEC: begin
        cmd.execute = 1'b1;
      end
      aeps_pkg::ST_DONE: begin
        in_stall   = out_busy;
        cmd.finish = !out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    cmd.capture = in_valid && !in_stall;
  end

endmodule

`default_nettype wire

// ===== src/aeps_datapath.sv =====
// Datapath of the scheduler: queue pointers and counts per bank and level,
// the task store memory and the result staging. Depends on aeps_pkg.
`default_nettype none

module aeps_datapath #(
  parameter int LEVELS     = aeps_pkg::LEVELS_DEF,
  parameter int FIFO_DEPTH = aeps_pkg::FIFO_DEPTH_DEF,
  parameter int ID_BITS    = aeps_pkg::ID_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire aeps_pkg::ctrl_cmd_t                 cmd,
  input  wire logic                                in_operation,
  input  wire logic [aeps_pkg::TASK_ID_W-1:0]      in_task_id,
  input  wire logic [aeps_pkg::STATIC_W-1:0]       in_static_level,
  input  wire logic [aeps_pkg::CURRENT_W-1:0]      in_current_level,
  input  wire logic                                in_demote,
  output aeps_pkg::result_t                        result
);

  localparam int LW  = $clog2(LEVELS);
  localparam int PW  = $clog2(FIFO_DEPTH);
  localparam int CW  = $clog2(FIFO_DEPTH + 1);
  localparam int SID = (ID_BITS < aeps_pkg::TASK_ID_W) ? ID_BITS : aeps_pkg::TASK_ID_W;
  localparam int SW  = SID + aeps_pkg::STATIC_W;
  localparam int AW  = 1 + LW + PW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [3:0]    LMAX  = 4'(LEVELS - 1);
  localparam logic [PW-1:0] PLAST = PW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] CFULL = CW'(FIFO_DEPTH);

  // Captured input beat.
  logic                               op_r;
  logic [SID-1:0]                     id_r;
  logic [aeps_pkg::STATIC_W-1:0]      stat_r;
  logic [aeps_pkg::CURRENT_W-1:0]     cur_r;
  logic                               dem_r;

  // Queue bookkeeping per bank and level.
  logic [PW-1:0] head_r [0:1][0:LEVELS-1];
  logic [PW-1:0] tail_r [0:1][0:LEVELS-1];
  logic [CW-1:0] cnt_r  [0:1][0:LEVELS-1];
  logic          active_r;

  // Task store: {static level, id} per slot.
  logic [SW-1:0] mem [0:MEM_DEPTH-1];
  logic [SW-1:0] rd_data_r;

  // Staged result.
  logic                          found_r;
  logic [SID-1:0]                id_res_r;
  logic [aeps_pkg::STATIC_W-1:0] stat_res_r;
  logic [aeps_pkg::DYN_W-1:0]    lvl_res_r;
  logic                          exp_r;
  logic                          ovf_r;
  logic                          from_mem_r;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == PLAST) ? '0 : p + PW'(1);
  endfunction

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      id_r   <= in_task_id[SID-1:0];
      stat_r <= in_static_level;
      cur_r  <= in_current_level;
      dem_r  <= in_demote;
    end
  end

  // Enqueue: demotion, expiry and target level with saturation.
  logic          enq_expired;
  logic [3:0]    enq_raw;
  logic [LW-1:0] enq_lvl;
  logic [3:0]    enq_lvl4;
  logic          enq_bank;
  logic          enq_full;

  always_comb begin
    enq_expired = dem_r && (cur_r == '0);
    if (enq_expired) begin
      enq_raw = (stat_r == '0) ? 4'd0 : 4'(stat_r) - 4'd1;
    end else begin
      enq_raw = dem_r ? 4'(cur_r) - 4'd1 : 4'(cur_r);
    end
    enq_lvl  = LW'((enq_raw > LMAX) ? LMAX : enq_raw);
    enq_lvl4 = 4'(enq_lvl);
    enq_bank = active_r ^ enq_expired;
    enq_full = (cnt_r[enq_bank][enq_lvl] == CFULL);
  end

  // Dequeue: bank swap decision and highest non-empty level.
  logic [1:0][LEVELS-1:0] nonempty;
  logic                   act_any;
  logic                   oth_any;
  logic                   deq_any;
  logic                   deq_bank;
  logic [LW-1:0]          deq_lvl;
  logic [3:0]             deq_lvl4;

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      for (int l = 0; l < LEVELS; l++) begin
        nonempty[b][l] = (cnt_r[b][l] != '0);
      end
    end
    act_any  = |nonempty[active_r];
    oth_any  = |nonempty[!active_r];
    deq_any  = act_any || oth_any;
    deq_bank = act_any ? active_r : !active_r;
    deq_lvl  = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (nonempty[deq_bank][l]) deq_lvl = LW'(l);
    end
    deq_lvl4 = 4'(deq_lvl);
  end

  // Task store address for the operation under way.
  logic [AW-1:0] mem_addr;
  logic          mem_we;

  always_comb begin
    if (op_r == aeps_pkg::OP_ENQUEUE) begin
      mem_addr = {enq_bank, enq_lvl, tail_r[enq_bank][enq_lvl]};
    end else begin
      mem_addr = {deq_bank, deq_lvl, head_r[deq_bank][deq_lvl]};
    end
    mem_we = cmd.execute && (op_r == aeps_pkg::OP_ENQUEUE) && !enq_full;
  end

  // Task store: a write on each enqueue that is queued, a registered read on every execute. The read data
  // holds until the next execute so a stalled result keeps its payload.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {stat_r, id_r};
    end
    if (cmd.execute) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // Queue pointers, counts and active bank.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 2; b++) begin
        for (int l = 0; l < LEVELS; l++) begin
          head_r[b][l] <= '0;
          tail_r[b][l] <= '0;
          cnt_r[b][l]  <= '0;
        end
      end
      active_r <= 1'b0;
    end else if (cmd.execute) begin
      if (op_r == aeps_pkg::OP_ENQUEUE) begin
        if (!enq_full) begin
          tail_r[enq_bank][enq_lvl] <= next_ptr(tail_r[enq_bank][enq_lvl]);
          cnt_r[enq_bank][enq_lvl]  <= cnt_r[enq_bank][enq_lvl] + CW'(1);
        end
      end else if (deq_any) begin
        active_r                  <= deq_bank;
        head_r[deq_bank][deq_lvl] <= next_ptr(head_r[deq_bank][deq_lvl]);
        cnt_r[deq_bank][deq_lvl]  <= cnt_r[deq_bank][deq_lvl] - CW'(1);
      end
    end
  end

  // Stage the result fields that do not come from the task store.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (op_r == aeps_pkg::OP_ENQUEUE) begin
        found_r    <= !enq_full;
        id_res_r   <= id_r;
        stat_res_r <= stat_r;
        lvl_res_r  <= enq_lvl4[1:0];
        exp_r      <= enq_expired && !enq_full;
        ovf_r      <= enq_full;
        from_mem_r <= 1'b0;
      end else begin
        found_r    <= deq_any;
        id_res_r   <= '0;
        stat_res_r <= '0;
        lvl_res_r  <= deq_any ? deq_lvl4[1:0] : '0;
        exp_r      <= 1'b0;
        ovf_r      <= 1'b0;
        from_mem_r <= deq_any;
      end
    end
  end

  // Assemble the result beat; a dequeue takes id and static level from the store.
  always_comb begin
    result.found         = found_r;
    result.task_id       = from_mem_r ? aeps_pkg::TASK_ID_W'(rd_data_r[SID-1:0])
                                      : aeps_pkg::TASK_ID_W'(id_res_r);
    result.static_level  = from_mem_r ? rd_data_r[SW-1:SID] : stat_res_r;
    result.dynamic_level = lvl_res_r;
    result.went_expired  = exp_r;
    result.overflow      = ovf_r;
  end

endmodule

`default_nettype wire

// ===== src/aeps_checker.sv =====
// Port-level checker for the active/expired priority scheduler, bound to the
// top level. Depends on aeps_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module aeps_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           in_operation,
  input wire logic [aeps_pkg::TASK_ID_W-1:0] in_task_id,
  input wire logic [aeps_pkg::STATIC_W-1:0]  in_static_level,
  input wire logic [aeps_pkg::CURRENT_W-1:0] in_current_level,
  input wire logic                           in_demote,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           out_found,
  input wire logic [aeps_pkg::TASK_ID_W-1:0] out_task_id,
  input wire logic [aeps_pkg::STATIC_W-1:0]  out_static_level,
  input wire logic [aeps_pkg::DYN_W-1:0]     out_dynamic_level,
  input wire logic                           out_went_expired,
  input wire logic                           out_overflow
);

  logic in_beat;
  logic in_unused;

  assign in_beat   = in_valid && !in_stall;
  assign in_unused = ^{in_operation, in_task_id, in_static_level, in_current_level, in_demote};

  // A stalled result beat holds.
  `AEPS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({out_found, out_task_id, out_static_level, out_dynamic_level, out_went_expired, out_overflow}))

  // The block is busy in the cycle after it takes a beat.
  `AEPS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_beat, in_stall)

  // A dropped task is never reported as queued or expired.
  `AEPS_ASSERT_IMP(a_overflow_excl, clk, rst_n, out_valid && out_overflow, !out_found && !out_went_expired)

  // Only a queued task can be marked expired.
  `AEPS_ASSERT_IMP(a_expired_found, clk, rst_n, out_valid && out_went_expired, out_found && !out_overflow)

  // An empty dequeue reports all-zero fields.
  `AEPS_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && !out_found && !out_overflow, (out_task_id == '0) && (out_static_level == '0) && (out_dynamic_level == '0) && !out_went_expired)

endmodule

bind active_expired_priority_scheduler_unit aeps_checker u_aeps_checker (.*);

`default_nettype wire
